>>> hw/rtl/pfe_pkg.sv
// Shared types, codes and helper functions for the Playfair encryptor.
package pfe_pkg;

	localparam int unsigned LETTERS = 26;
	localparam int unsigned CELLS   = 25;

	localparam logic [1:0] MODE_KEY    = 2'd0;
	localparam logic [1:0] MODE_FINISH = 2'd1;
	localparam logic [1:0] MODE_PLAIN  = 2'd2;
	localparam logic [1:0] MODE_END    = 2'd3;

	localparam logic [4:0] CODE_I    = 5'd8;
	localparam logic [4:0] CODE_J    = 5'd9;
	localparam logic [4:0] CODE_X    = 5'd23;
	localparam logic [4:0] CODE_Z    = 5'd25;
	localparam logic [4:0] CODE_LAST = 5'd25;
	localparam logic [4:0] CELL_FULL = 5'd25;
	localparam logic [2:0] SIDE_LAST = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_LOOKUP,
		ST_EMIT_A,
		ST_EMIT_B
	} state_t;

	typedef enum logic {
		PH_KEYING,
		PH_ENCRYPTING
	} phase_t;

	typedef struct packed {
		logic take;
		logic fill_step;
		logic sq_rd;
		logic sel_b;
	} cmd_t;

	typedef struct packed {
		logic start_fill;
		logic makes_pair;
		logic fill_last;
	} stat_t;

	function automatic logic [4:0] fold(input logic [4:0] c);
		return (c == CODE_J) ? CODE_I : c;
	endfunction

	function automatic logic [4:0] pad_for(input logic [4:0] c);
		return (c == CODE_X) ? CODE_Z : CODE_X;
	endfunction

	function automatic logic [2:0] row_of(input logic [4:0] idx);
		logic [8:0] prod;
		prod = 9'(idx) * 9'd13;
		return prod[8:6];
	endfunction

	function automatic logic [2:0] col_of(input logic [4:0] idx);
		logic [2:0] r;
		logic [4:0] diff;
		r = row_of(idx);
		diff = idx - (5'({r, 2'b00}) + 5'(r));
		return diff[2:0];
	endfunction

	function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
		return 5'({r, 2'b00}) + 5'(r) + 5'(c);
	endfunction

	function automatic logic [2:0] wrap_inc(input logic [2:0] v);
		return (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
	endfunction

endpackage

>>> hw/rtl/playfair_encryptor_core.sv
// Top level of the Playfair encryptor: controller, datapath and stream ports.
//
//   Channel | Direction | Handshake               | Payload
//   s_axis  | in        | s_axis_tvalid/tready    | tuser: mode, tdata: letter
//   m_axis  | out       | m_axis_tvalid/tready    | tdata: cipher letter, tlast: second of pair
//
// A key letter, a held plaintext letter or an ignored item is accepted and the controller stays idle.
// A finish-key item is accepted and then starts a sweep of one alphabet letter per cycle.
// An item that closes a pair passes through the accept, which reads both positions, the square
// read and two output items, each of which a stalled output holds.
// Reset clears the presence map, the fill count, the held letter and returns to keying.
// A stalled output holds its item; no new input item is taken until both are delivered.
module playfair_encryptor_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [4:0] letter, [7:5] zero
	input  logic [1:0] s_axis_tuser,  // [1:0] mode
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [4:0] cipher_letter, [7:5] zero
	output logic       m_axis_tlast
);

	pfe_pkg::cmd_t  cmd;
	pfe_pkg::stat_t stat;
	logic [4:0]     cipher_letter;

	pfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pfe_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (s_axis_tuser),
		.letter        (s_axis_tdata[4:0]),
		.cmd           (cmd),
		.stat          (stat),
		.cipher_letter (cipher_letter)
	);

	assign m_axis_tdata = {3'b000, cipher_letter};
	assign m_axis_tlast = cmd.sel_b;

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input taken while an output item is pending");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
		else $error("first letter of a pair not followed by the second");

	a_pair_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
		else $error("output item after the end of a pair");

	a_fill_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step |-> (!s_axis_tready && !m_axis_tvalid))
		else $error("ports active during the key fill sweep");

endmodule

>>> hw/rtl/pfe_ctrl.sv
// Controller state machine that sequences key fill, lookups and output items.
module pfe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  pfe_pkg::stat_t stat,
	output pfe_pkg::cmd_t  cmd
);

	pfe_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pfe_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (stat.start_fill) begin
						state_d = pfe_pkg::ST_FILL;
					end else if (stat.makes_pair) begin
						state_d = pfe_pkg::ST_LOOKUP;
					end
				end
			end
			pfe_pkg::ST_FILL: begin
				if (stat.fill_last) begin
					state_d = pfe_pkg::ST_IDLE;
				end
			end
			pfe_pkg::ST_LOOKUP: begin
				state_d = pfe_pkg::ST_EMIT_A;
			end
			pfe_pkg::ST_EMIT_A: begin
				if (out_ready) begin
					state_d = pfe_pkg::ST_EMIT_B;
				end
			end
			pfe_pkg::ST_EMIT_B: begin
				if (out_ready) begin
					state_d = pfe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfe_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			pfe_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			pfe_pkg::ST_FILL: begin
				cmd.fill_step = 1'b1;
			end
			pfe_pkg::ST_LOOKUP: begin
				cmd.sq_rd = 1'b1;
			end
			pfe_pkg::ST_EMIT_A: begin
				out_valid = 1'b1;
			end
			pfe_pkg::ST_EMIT_B: begin
				out_valid = 1'b1;
				cmd.sel_b = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> hw/rtl/pfe_datapath.sv
// Datapath with the square, the letter position map and the pairing logic.
module pfe_datapath (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     mode,
	input  logic [4:0]     letter,
	input  pfe_pkg::cmd_t  cmd,
	output pfe_pkg::stat_t stat,
	output logic [4:0]     cipher_letter
);

	logic [4:0] sq_mem  [pfe_pkg::CELLS];
	logic [4:0] pos_mem [pfe_pkg::LETTERS];

	logic [pfe_pkg::LETTERS-1:0] present_q, present_eff;
	logic [4:0]                  fill_q, fill_eff;
	pfe_pkg::phase_t             phase_q;
	logic [4:0]                  pend_q;
	logic                        pend_vld_q;
	logic [4:0]                  sweep_q;
	logic [4:0]                  pos_a_q, pos_b_q;
	logic [4:0]                  sq_a_q, sq_b_q;

	logic       letter_ok, key_item, new_key, place_try, place_ok;
	logic       plain_item, end_item, pair_now, hold_first, same_letter;
	logic [4:0] c_fold, place_c, pair_b;
	logic [2:0] r1, c1, r2, c2;
	logic [4:0] oa, ob;

	assign letter_ok   = letter <= pfe_pkg::CODE_LAST;
	assign c_fold      = pfe_pkg::fold(letter);
	assign key_item    = cmd.take && (mode == pfe_pkg::MODE_KEY) && letter_ok;
	assign new_key     = key_item && (phase_q == pfe_pkg::PH_ENCRYPTING);
	assign present_eff = new_key ? '0 : present_q;
	assign fill_eff    = new_key ? 5'd0 : fill_q;
	assign place_c     = cmd.fill_step ? sweep_q : c_fold;
	assign place_try   = key_item || (cmd.fill_step && (sweep_q != pfe_pkg::CODE_J));
	assign place_ok    = place_try && !present_eff[place_c] && (fill_eff < pfe_pkg::CELL_FULL);

	assign plain_item  = (phase_q == pfe_pkg::PH_ENCRYPTING) && (mode == pfe_pkg::MODE_PLAIN)
		&& letter_ok;
	assign end_item    = (phase_q == pfe_pkg::PH_ENCRYPTING) && (mode == pfe_pkg::MODE_END);
	assign same_letter = c_fold == pend_q;
	assign hold_first  = plain_item && !pend_vld_q;
	assign pair_now    = pend_vld_q && (plain_item || end_item);
	assign pair_b      = (end_item || same_letter) ? pfe_pkg::pad_for(pend_q) : c_fold;

	assign stat.start_fill = (mode == pfe_pkg::MODE_FINISH) && (phase_q == pfe_pkg::PH_KEYING);
	assign stat.makes_pair = pair_now;
	assign stat.fill_last  = sweep_q == pfe_pkg::CODE_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q  <= '0;
			fill_q     <= '0;
			phase_q    <= pfe_pkg::PH_KEYING;
			pend_q     <= '0;
			pend_vld_q <= 1'b0;
			sweep_q    <= '0;
		end else begin
			if (key_item || cmd.fill_step) begin
				present_q <= present_eff
					| (place_ok ? (pfe_pkg::LETTERS'(1) << place_c) : '0);
				fill_q    <= fill_eff + 5'(place_ok);
			end
			if (new_key) begin
				phase_q    <= pfe_pkg::PH_KEYING;
				pend_vld_q <= 1'b0;
			end
			if (cmd.take && stat.start_fill) begin
				sweep_q <= '0;
			end else if (cmd.fill_step) begin
				sweep_q <= sweep_q + 5'd1;
				if (stat.fill_last) begin
					phase_q <= pfe_pkg::PH_ENCRYPTING;
				end
			end
			if (cmd.take && hold_first) begin
				pend_q     <= c_fold;
				pend_vld_q <= 1'b1;
			end else if (cmd.take && pair_now && (end_item || !same_letter)) begin
				pend_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (place_ok) begin
			sq_mem[fill_eff] <= place_c;
			pos_mem[place_c] <= fill_eff;
		end
		if (cmd.take && pair_now) begin
			pos_a_q <= pos_mem[pend_q];
			pos_b_q <= pos_mem[pair_b];
		end
	end

	always_comb begin
		r1 = pfe_pkg::row_of(pos_a_q);
		c1 = pfe_pkg::col_of(pos_a_q);
		r2 = pfe_pkg::row_of(pos_b_q);
		c2 = pfe_pkg::col_of(pos_b_q);
		if (r1 == r2) begin
			oa = pfe_pkg::cell_of(r1, pfe_pkg::wrap_inc(c1));
			ob = pfe_pkg::cell_of(r2, pfe_pkg::wrap_inc(c2));
		end else if (c1 == c2) begin
			oa = pfe_pkg::cell_of(pfe_pkg::wrap_inc(r1), c1);
			ob = pfe_pkg::cell_of(pfe_pkg::wrap_inc(r2), c2);
		end else begin
			oa = pfe_pkg::cell_of(r1, c2);
			ob = pfe_pkg::cell_of(r2, c1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_rd) begin
			sq_a_q <= sq_mem[oa];
			sq_b_q <= sq_mem[ob];
		end
	end

	assign cipher_letter = cmd.sel_b ? sq_b_q : sq_a_q;

endmodule
